// ===== hdl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// table geometry and allocation granule (granule is a power of two)
	localparam int MAX_ENTRIES = 32;
	localparam int ALIGN_UNIT  = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int DATA_W      = 32;
	localparam int AMT_W       = DATA_W + 1;

	// request kinds
	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// one block table entry as stored in the table RAM
	typedef struct packed {
		logic              busy;
		logic [DATA_W-1:0] size;
		logic [DATA_W-1:0] start;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// flags from the shared compare unit
	typedef struct packed {
		logic fits;      // entry size >= rounded amount
		logic le_best;   // entry size <= best size so far
		logic start_eq;  // entry start == release offset
	} cmp_res_t;

endpackage

// ===== hdl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/bfa_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// bfa_cmp_unit
// Shared compare and add unit: checks one table entry per cycle during the
// scan and forms the new pool end when the table is updated.
// ----------------------------------------------------------------------------
module bfa_cmp_unit
	import bfa_pkg::*;
(
	input  logic [DATA_W-1:0] entry_size,
	input  logic [DATA_W-1:0] entry_start,
	input  logic [AMT_W-1:0]  amount,
	input  logic [DATA_W-1:0] best_size,
	input  logic [DATA_W-1:0] offset,
	input  logic [DATA_W-1:0] add_base,
	output cmp_res_t          res,
	output logic [AMT_W-1:0]  sum
);

	// entry checks
	always_comb begin
		res.fits     = {1'b0, entry_size} >= amount;
		res.le_best  = entry_size <= best_size;
		res.start_eq = entry_start == offset;
	end

	// pool end with carry out for overflow detection
	assign sum = {1'b0, add_base} + amount;

endmodule

// ===== hdl/best_fit_block_allocator.sv =====
// Each request reads the table once, one RAM read per block below the block
// count, and then decides the outcome and any table update.
// One request at a time: the next is accepted only after the previous result
// is registered, so a stalled result also holds off the next request.
// Reset: arst_n clears the block count, pool total and control state; the
// table contents stay undefined and only entries below the count are read.
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit pool allocator over an ordered block table held in a RAM, with a
// small sequencer driving a shared compare and add unit.
// ----------------------------------------------------------------------------
module best_fit_block_allocator
	import bfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // request_size [31:0], release_offset [63:32]
	input  logic [0:0]  s_tuser,   // mode [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // grant_offset [31:0], pool_total [63:32]
	output logic [1:0]  m_tuser    // status [1:0]
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	localparam logic [AMT_W-1:0] ALIGN_MASK = AMT_W'(ALIGN_UNIT - 1);

	state_t             state_q;
	logic               mode_q;
	logic [AMT_W-1:0]   amount_q;
	logic [DATA_W-1:0]  offset_q;
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  total_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               rd_vld_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               best_found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [DATA_W-1:0]  best_start_q;
	logic [DATA_W-1:0]  best_size_q;
	logic               last_busy_q;
	logic [DATA_W-1:0]  last_start_q;
	logic               match_found_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [DATA_W-1:0]  match_size_q;
	logic               m_tvalid_q;
	logic [DATA_W-1:0]  out_offset_q;
	logic [DATA_W-1:0]  out_total_q;
	status_t            out_status_q;

	logic               accept;
	logic               issue;
	logic               out_free;
	logic [AMT_W-1:0]   amount_raw;
	logic [AMT_W-1:0]   amount_new;
	logic [IDX_W-1:0]   last_idx;
	logic               last_free;
	entry_t             rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	cmp_res_t           cmp;
	logic [AMT_W-1:0]   sum;
	logic [DATA_W-1:0]  add_base;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_entry;
	logic               upd_total;
	logic               upd_count;
	logic [DATA_W-1:0]  res_offset;
	status_t            res_status;

	assign s_tready = state_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// round the request size up to the allocation granule
	assign amount_raw = {1'b0, s_tdata[31:0]} + ALIGN_MASK;
	assign amount_new = amount_raw & ~ALIGN_MASK;

	assign issue     = (state_q == S_SCAN) && (scan_idx_q < count_q);
	assign last_idx  = IDX_W'(count_q - CNT_W'(1));
	assign last_free = (count_q != '0) && !last_busy_q;
	assign rd_entry  = entry_t'(rd_data);
	assign add_base  = last_free ? last_start_q : total_q;

	bfa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	bfa_cmp_unit u_cmp (
		.entry_size  (rd_entry.size),
		.entry_start (rd_entry.start),
		.amount      (amount_q),
		.best_size   (best_size_q),
		.offset      (offset_q),
		.add_base    (add_base),
		.res         (cmp),
		.sum         (sum)
	);

	// decide the outcome of the request and the table update
	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = best_idx_q;
		wr_entry   = '{busy: 1'b1, size: best_size_q, start: best_start_q};
		upd_total  = 1'b0;
		upd_count  = 1'b0;
		res_offset = '0;
		res_status = ST_OK;
		if (mode_q == MODE_RELEASE) begin
			res_offset = offset_q;
			if (match_found_q) begin
				wr_en    = 1'b1;
				wr_idx   = match_idx_q;
				wr_entry = '{busy: 1'b0, size: match_size_q, start: offset_q};
			end else begin
				res_status = ST_NOT_FOUND;
			end
		end else if (amount_q[AMT_W-1]) begin
			res_status = ST_OVERFLOW;
		end else if (best_found_q) begin
			wr_en      = 1'b1;
			res_offset = best_start_q;
		end else if (last_free) begin
			if (sum[AMT_W-1]) begin
				res_status = ST_OVERFLOW;
			end else begin
				wr_en      = 1'b1;
				wr_idx     = last_idx;
				wr_entry   = '{busy: 1'b1, size: amount_q[DATA_W-1:0], start: last_start_q};
				upd_total  = 1'b1;
				res_offset = last_start_q;
			end
		end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
			res_status = ST_FULL;
		end else if (sum[AMT_W-1]) begin
			res_status = ST_OVERFLOW;
		end else begin
			wr_en      = 1'b1;
			wr_idx     = count_q[IDX_W-1:0];
			wr_entry   = '{busy: 1'b1, size: amount_q[DATA_W-1:0], start: total_q};
			upd_total  = 1'b1;
			upd_count  = 1'b1;
			res_offset = total_q;
		end
		// hold the update until the result register can take the outcome
		if (!(state_q == S_DECIDE && out_free)) begin
			wr_en     = 1'b0;
			upd_total = 1'b0;
			upd_count = 1'b0;
		end
	end

	// sequencer and persistent counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			scan_idx_q <= '0;
			rd_vld_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (m_tready && state_q != S_DECIDE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					scan_idx_q <= '0;
					rd_vld_q   <= 1'b0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_q <= issue;
					if (issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end else if (!rd_vld_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (upd_total) begin
				total_q <= sum[DATA_W-1:0];
			end
			if (upd_count) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// request capture, scan bookkeeping and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q        <= s_tuser[0];
			amount_q      <= amount_new;
			offset_q      <= s_tdata[63:32];
			best_found_q  <= 1'b0;
			best_size_q   <= '0;
			match_found_q <= 1'b0;
			last_busy_q   <= 1'b1;
		end
		if (issue) begin
			rd_idx_q <= scan_idx_q[IDX_W-1:0];
		end
		if (state_q == S_SCAN && rd_vld_q) begin
			// keep the smallest fitting free block, later block wins a tie
			if (!rd_entry.busy && cmp.fits && (!best_found_q || cmp.le_best)) begin
				best_found_q <= 1'b1;
				best_idx_q   <= rd_idx_q;
				best_start_q <= rd_entry.start;
				best_size_q  <= rd_entry.size;
			end
			// remember the last block of the table
			if (rd_idx_q == last_idx) begin
				last_busy_q  <= rd_entry.busy;
				last_start_q <= rd_entry.start;
			end
			// first block whose start matches the release offset
			if (cmp.start_eq && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= rd_idx_q;
				match_size_q  <= rd_entry.size;
			end
		end
		if (state_q == S_DECIDE && out_free) begin
			out_offset_q <= res_offset;
			out_status_q <= res_status;
			out_total_q  <= upd_total ? sum[DATA_W-1:0] : total_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_total_q, out_offset_q};
	assign m_tuser  = out_status_q;

endmodule
